FILE: hw/rtl/stc_pkg.sv
// shared constants, types and helpers for the symbol table cam
`timescale 1ns / 1ps

package stc_pkg;

    // default table depth
    localparam int CAPACITY_DEF = 64;

    // cells folded into one first-level reduction group
    localparam int GROUP_SIZE = 8;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // type class of a symbol
    localparam logic CLASS_IDENTIFIER = 1'b1;
    localparam logic CLASS_OPERATOR   = 1'b0;

    // per-cell control bundle
    typedef struct packed {
        logic cmp;
        logic live;
        logic load;
        logic shift;
    } t_cell_ctrl;

    // ascii letter test
    function automatic logic sym_class(input logic [7:0] sym);
        logic letter;
        letter = ((sym >= 8'h41) && (sym <= 8'h5A)) || ((sym >= 8'h61) && (sym <= 8'h7A));
        return letter ? CLASS_IDENTIFIER : CLASS_OPERATOR;
    endfunction

endpackage

FILE: hw/rtl/stc_if.sv
// request and response channel interfaces of the symbol table cam
`timescale 1ns / 1ps

interface stc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] symbol;

    modport source (output valid, output req_type, output symbol, input ready);
    modport sink   (input valid, input req_type, input symbol, output ready);
endinterface

interface stc_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] position;
    logic       is_identifier;
    logic [6:0] live_count;

    modport source (output valid, output status, output position, output is_identifier,
                    output live_count, input ready);
    modport sink   (input valid, input status, input position, input is_identifier,
                    input live_count, output ready);
endinterface

FILE: hw/rtl/symbol_table_cam.sv
// top level of the symbol table cam: cell row, match reduction and control
`timescale 1ns / 1ps

// Packed symbol table of CAPACITY one-byte keys held in insertion order.
// Request channel i_req carries req_type (insert, delete, search) and a
// symbol; response channel o_rsp returns status, position, is_identifier
// and the live count after the request, one response per request.
// A request passes through the states accept, compare (every cell compares
// its key), group fold (the match flags are folded in groups of eight) and
// update (fold the groups, update the cells and load the response register).
// A single shared request register holds the request, so a new request is
// taken only once the previous one has been written into the response
// register.
// Delete compacts the row in the update cycle: every cell at or above the
// match takes the key of its upper neighbor.
// If the receiver stalls, the response register holds its item and the
// next request waits in the update cycle until the register is free.
// Synchronous reset empties the table (live count zero) at once; key
// storage is not cleared, as only live slots are ever compared.
module symbol_table_cam #(
    parameter int CAPACITY = stc_pkg::CAPACITY_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    stc_req_if.sink      i_req,
    stc_rsp_if.source    o_rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int GS = stc_pkg::GROUP_SIZE;
    localparam int NG = (CAPACITY + GS - 1) / GS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_RED  = 4'b0100,
        S_UPD  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [1:0]         r_req;
    logic [7:0]         r_sym;
    logic [CW-1:0]      r_count, n_count;

    logic [NG-1:0]      r_grp_any;
    logic [IW-1:0]      r_grp_idx [NG];
    logic [NG-1:0]      w_grp_any;
    logic [IW-1:0]      w_grp_idx [NG];

    logic [CAPACITY-1:0] w_hit;
    logic [7:0]          w_key [CAPACITY];
    stc_pkg::t_cell_ctrl w_ctrl [CAPACITY];

    logic               w_any;
    logic [IW-1:0]      w_pos;
    logic               w_commit;
    logic               w_ins_ok;
    logic               w_del_ok;
    logic               w_full;
    logic [1:0]         w_status;
    logic [IW-1:0]      w_res_pos;
    logic [15:0]        w_pos_ext;
    logic [15:0]        w_cnt_ext;

    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic [5:0]         r_out_pos;
    logic               r_out_class;
    logic [6:0]         r_out_count;

    // row of cells, each pulling from its upper neighbor on delete
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [7:0] w_next;
        if (i == CAPACITY - 1) begin : g_top
            assign w_next = 8'h00;
        end else begin : g_mid
            assign w_next = w_key[i + 1];
        end

        assign w_ctrl[i].cmp   = (r_state == S_CMP);
        assign w_ctrl[i].live  = (CW'(i) < r_count);
        assign w_ctrl[i].load  = w_commit && w_ins_ok && (CW'(i) == r_count);
        assign w_ctrl[i].shift = w_commit && w_del_ok && (IW'(i) >= w_pos);

        stc_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl[i]),
            .i_sym      (r_sym),
            .i_next_key (w_next),
            .o_key      (w_key[i]),
            .o_hit      (w_hit[i])
        );
    end

    // first fold: keys are unique, so or-ing the indices of hits gives the slot
    always_comb begin
        int j;
        for (int g = 0; g < NG; g++) begin
            w_grp_any[g] = 1'b0;
            w_grp_idx[g] = '0;
            for (int k = 0; k < GS; k++) begin
                j = g * GS + k;
                if (j < CAPACITY) begin
                    if (w_hit[j]) begin
                        w_grp_any[g] = 1'b1;
                        w_grp_idx[g] = w_grp_idx[g] | IW'(j);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RED) begin
            r_grp_any <= w_grp_any;
            for (int g = 0; g < NG; g++) begin
                r_grp_idx[g] <= w_grp_idx[g];
            end
        end
    end

    // second fold over the groups
    always_comb begin
        w_any = 1'b0;
        w_pos = '0;
        for (int g = 0; g < NG; g++) begin
            if (r_grp_any[g]) begin
                w_any = 1'b1;
                w_pos = w_pos | r_grp_idx[g];
            end
        end
    end

    // request outcome
    always_comb begin
        w_full    = (r_count >= CW'(CAPACITY));
        w_ins_ok  = 1'b0;
        w_del_ok  = 1'b0;
        w_status  = stc_pkg::ST_MISSING;
        w_res_pos = '0;
        n_count   = r_count;
        case (r_req)
            stc_pkg::REQ_INSERT: begin
                if (w_any) begin
                    w_status = stc_pkg::ST_DUP;
                end else if (w_full) begin
                    w_status = stc_pkg::ST_FULL;
                end else begin
                    w_ins_ok  = 1'b1;
                    w_status  = stc_pkg::ST_OK;
                    w_res_pos = r_count[IW-1:0];
                    n_count   = r_count + CW'(1);
                end
            end
            stc_pkg::REQ_DELETE: begin
                if (w_any) begin
                    w_del_ok  = 1'b1;
                    w_status  = stc_pkg::ST_OK;
                    w_res_pos = w_pos;
                    n_count   = r_count - CW'(1);
                end
            end
            stc_pkg::REQ_SEARCH: begin
                if (w_any) begin
                    w_status  = stc_pkg::ST_OK;
                    w_res_pos = w_pos;
                end
            end
            default: begin
                w_status = stc_pkg::ST_MISSING;
            end
        endcase
    end

    assign w_commit  = (r_state == S_UPD) && (!r_out_valid || o_rsp.ready);
    assign w_pos_ext = 16'(w_res_pos);
    assign w_cnt_ext = 16'(n_count);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_RED;
            end
            S_RED: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count <= n_count;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.req_type;
            r_sym <= i_req.symbol;
        end
    end

    // no request is taken while reset is held
    assign i_req.ready = i_rst_n && (r_state == S_IDLE);

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_status <= w_status;
            r_out_pos    <= w_pos_ext[5:0];
            r_out_class  <= stc_pkg::sym_class(r_sym);
            r_out_count  <= w_cnt_ext[6:0];
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.position      = r_out_pos;
    assign o_rsp.is_identifier = r_out_class;
    assign o_rsp.live_count    = r_out_count;

    // live count never exceeds the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("live count above capacity");

    // stored keys stay unique, so at most one live slot matches
    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED) |-> ($countones(w_hit) <= 1))
        else $error("more than one slot matched");

    // a successful insert grows the table by exactly one entry
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_ins_ok) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the table");

    // a successful delete only happens on a non-empty table
    a_delete_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_del_ok) |-> (r_count != '0))
        else $error("delete on empty table");

endmodule

FILE: hw/rtl/stc_cell.sv
// one table slot: key storage, match flag and shift from the upper neighbor
`timescale 1ns / 1ps

module stc_cell (
    input  logic               i_clk,
    input  stc_pkg::t_cell_ctrl i_ctrl,
    input  logic [7:0]         i_sym,
    input  logic [7:0]         i_next_key,
    output logic [7:0]         o_key,
    output logic               o_hit
);

    logic [7:0] r_key;
    logic       r_hit;

    // match flag, only meaningful for live slots
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp) begin
            r_hit <= (r_key == i_sym) && i_ctrl.live;
        end
    end

    // append writes the new key, delete pulls the neighbor's key down
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_key <= i_sym;
        end else if (i_ctrl.shift) begin
            r_key <= i_next_key;
        end
    end

    assign o_key = r_key;
    assign o_hit = r_hit;

endmodule
